@@ design/lca_pkg.sv @@
// ----------------------------------------------------------------------------
// lca_pkg
// Shared widths, command codes and level helpers of the binary-lifting
// lowest common ancestor engine.
// ----------------------------------------------------------------------------
package lca_pkg;

	localparam int unsigned VERT_W     = 10;
	localparam int unsigned CNT_W      = 11;
	localparam int unsigned MAX_VERTS  = 1024;
	localparam int unsigned MAX_LEVELS = 10;
	localparam int unsigned LVL_W      = 4;
	localparam int unsigned TAB_AW     = VERT_W + LVL_W;
	localparam int unsigned ENT_W      = VERT_W + 1;

	localparam logic [1:0] CMD_LOAD  = 2'd0;
	localparam logic [1:0] CMD_BUILD = 2'd1;
	localparam logic [1:0] CMD_QUERY = 2'd2;
	localparam logic [1:0] CMD_NOP   = 2'd3;

	localparam logic [CNT_W-1:0] COUNT_RESET = CNT_W'(MAX_VERTS);

	typedef logic [VERT_W-1:0] vert_t;
	typedef logic [ENT_W-1:0]  entry_t;
	typedef logic [LVL_W-1:0]  lvl_t;

	function automatic logic [CNT_W-1:0] clamp_count(input logic [CNT_W-1:0] n);
		logic [CNT_W-1:0] r;
		r = n;
		if (n == '0)
			r = CNT_W'(1);
		else if (n > CNT_W'(MAX_VERTS))
			r = CNT_W'(MAX_VERTS);
		return r;
	endfunction

	function automatic lvl_t level_count(input logic [CNT_W-1:0] n);
		lvl_t lv;
		lv = LVL_W'(1);
		for (int i = 1; i < CNT_W; i++) begin
			if ((CNT_W'(1) << i) < n)
				lv = LVL_W'(i + 1);
		end
		if (lv > LVL_W'(MAX_LEVELS))
			lv = LVL_W'(MAX_LEVELS);
		return lv;
	endfunction

endpackage

@@ design/lowest_common_ancestor_binary_lifting.sv @@
// ----------------------------------------------------------------------------
// lowest_common_ancestor_binary_lifting
// Binary-lifting LCA engine: ancestor table and depth store in synchronous
// memories, filled by load and build requests and walked by query requests.
// ----------------------------------------------------------------------------
//  channel | handshake            | payload
//  in      | in_valid / in_stall  | cmd, vertex_a, vertex_b, has_parent, depth
//  out     | out_valid / out_stall| ancestor, answer_valid
//  cfg     | cfg_valid / cfg_ready| cfg_data (vertex_count)
//
//  load writes the depth store and level 0 of the ancestor table. build moves
//  one vertex at a time through the ancestor table read port. query waits on
//  the table read latency at each lifting step.
//  one request at a time; in_stall is high until the result reaches the
//  output register, which may still wait on out_stall while the next request
//  is taken. reset clears control only, memories stay unknown until written.
module lowest_common_ancestor_binary_lifting (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [1:0]                 cmd,
	input  lca_pkg::vert_t             vertex_a,
	input  lca_pkg::vert_t             vertex_b,
	input  logic                       has_parent,
	input  lca_pkg::vert_t             depth,
	output logic                       out_valid,
	input  logic                       out_stall,
	output lca_pkg::vert_t             ancestor,
	output logic                       answer_valid,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [lca_pkg::CNT_W-1:0]  cfg_data
);
	import lca_pkg::*;

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_B_RD = 4'd1;
	localparam logic [3:0] ST_B_P  = 4'd2;
	localparam logic [3:0] ST_B_W  = 4'd3;
	localparam logic [3:0] ST_Q_D1 = 4'd4;
	localparam logic [3:0] ST_Q_D2 = 4'd5;
	localparam logic [3:0] ST_Q_D3 = 4'd6;
	localparam logic [3:0] ST_Q_L  = 4'd7;
	localparam logic [3:0] ST_Q_LD = 4'd8;
	localparam logic [3:0] ST_Q_C  = 4'd9;
	localparam logic [3:0] ST_Q_B  = 4'd10;
	localparam logic [3:0] ST_Q_BD = 4'd11;
	localparam logic [3:0] ST_Q_F  = 4'd12;
	localparam logic [3:0] ST_Q_FD = 4'd13;
	localparam logic [3:0] ST_FIN  = 4'd14;

	entry_t tab_mem [0:(1 << TAB_AW)-1];
	vert_t  dep_mem [0:MAX_VERTS-1];

	logic [3:0]        state_q;
	logic [CNT_W-1:0]  count_q;
	logic [CNT_W-1:0]  n_q;
	lvl_t              lv_q;
	lvl_t              built_lv_q;
	lvl_t              k_q;
	vert_t             a_q;
	vert_t             b_q;
	vert_t             v_q;
	vert_t             da_q;
	vert_t             diff_q;
	logic              pv_q;
	vert_t             res_q;
	logic              resv_q;
	logic              out_valid_q;
	vert_t             ancestor_q;
	logic              answer_valid_q;

	entry_t            rda_q;
	entry_t            rdb_q;
	vert_t             dq;
	logic [TAB_AW-1:0] rda_addr;
	logic [TAB_AW-1:0] rdb_addr;
	vert_t             dep_addr;
	logic              tab_we;
	logic [TAB_AW-1:0] tab_waddr;
	entry_t            tab_wdata;
	logic              in_acc;
	logic              out_free;
	vert_t             db;

	assign in_stall     = (state_q != ST_IDLE);
	assign in_acc       = in_valid && !in_stall;
	assign cfg_ready    = 1'b1;
	assign out_free     = !out_valid_q || !out_stall;
	assign out_valid    = out_valid_q;
	assign ancestor     = ancestor_q;
	assign answer_valid = answer_valid_q;
	assign db           = dq;

	always_comb begin
		rda_addr  = {v_q, k_q};
		rdb_addr  = {b_q, k_q};
		dep_addr  = a_q;
		tab_we    = 1'b0;
		tab_waddr = {vertex_a, LVL_W'(0)};
		tab_wdata = has_parent ? {1'b1, vertex_b} : '0;
		case (state_q)
			ST_IDLE: begin
				tab_we = in_acc && (cmd == CMD_LOAD);
			end
			ST_B_P: begin
				rda_addr = {rda_q[VERT_W-1:0], k_q};
			end
			ST_B_W: begin
				tab_we    = 1'b1;
				tab_waddr = {v_q, k_q + LVL_W'(1)};
				tab_wdata = pv_q ? rda_q : '0;
			end
			ST_Q_D2: begin
				dep_addr = b_q;
			end
			ST_Q_L: begin
				rda_addr = {a_q, k_q};
			end
			ST_Q_B: begin
				rda_addr = {a_q, k_q};
			end
			ST_Q_F: begin
				rdb_addr = {b_q, LVL_W'(0)};
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (tab_we)
			tab_mem[tab_waddr] <= tab_wdata;
		if (in_acc && (cmd == CMD_LOAD))
			dep_mem[vertex_a] <= depth;
		rda_q <= tab_mem[rda_addr];
		rdb_q <= tab_mem[rdb_addr];
		dq    <= dep_mem[dep_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			count_q        <= COUNT_RESET;
			built_lv_q     <= level_count(COUNT_RESET);
			out_valid_q    <= 1'b0;
			ancestor_q     <= '0;
			answer_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready)
				count_q <= cfg_data;
			if (out_valid_q && !out_stall && (state_q != ST_FIN))
				out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						res_q  <= '0;
						resv_q <= 1'b0;
						a_q    <= vertex_a;
						b_q    <= vertex_b;
						case (cmd)
							CMD_BUILD: begin
								n_q <= clamp_count(count_q);
								lv_q <= level_count(clamp_count(count_q));
								k_q <= '0;
								v_q <= '0;
								if (level_count(clamp_count(count_q)) == LVL_W'(1)) begin
									built_lv_q <= LVL_W'(1);
									state_q    <= ST_FIN;
								end else begin
									state_q <= ST_B_RD;
								end
							end
							CMD_QUERY: state_q <= ST_Q_D1;
							default:   state_q <= ST_FIN;
						endcase
					end
				end
				ST_B_RD: state_q <= ST_B_P;
				ST_B_P: begin
					pv_q    <= rda_q[VERT_W];
					state_q <= ST_B_W;
				end
				ST_B_W: begin
					state_q <= ST_B_RD;
					if ({1'b0, v_q} == n_q - CNT_W'(1)) begin
						v_q <= '0;
						if (k_q + LVL_W'(2) == lv_q) begin
							built_lv_q <= lv_q;
							state_q    <= ST_FIN;
						end else begin
							k_q <= k_q + LVL_W'(1);
						end
					end else begin
						v_q <= v_q + VERT_W'(1);
					end
				end
				ST_Q_D1: state_q <= ST_Q_D2;
				ST_Q_D2: begin
					da_q    <= dq;
					state_q <= ST_Q_D3;
				end
				ST_Q_D3: begin
					if (da_q < db) begin
						a_q    <= b_q;
						b_q    <= a_q;
						diff_q <= db - da_q;
					end else begin
						diff_q <= da_q - db;
					end
					k_q     <= built_lv_q - LVL_W'(1);
					state_q <= ST_Q_L;
				end
				ST_Q_L: begin
					if (diff_q[k_q])
						state_q <= ST_Q_LD;
					else if (k_q == '0)
						state_q <= ST_Q_C;
					else
						k_q <= k_q - LVL_W'(1);
				end
				ST_Q_LD: begin
					if (!rda_q[VERT_W]) begin
						state_q <= ST_FIN;
					end else begin
						a_q <= rda_q[VERT_W-1:0];
						if (k_q == '0) begin
							state_q <= ST_Q_C;
						end else begin
							k_q     <= k_q - LVL_W'(1);
							state_q <= ST_Q_L;
						end
					end
				end
				ST_Q_C: begin
					if (a_q == b_q) begin
						res_q   <= a_q;
						resv_q  <= 1'b1;
						state_q <= ST_FIN;
					end else begin
						k_q     <= built_lv_q - LVL_W'(1);
						state_q <= ST_Q_B;
					end
				end
				ST_Q_B: state_q <= ST_Q_BD;
				ST_Q_BD: begin
					if ((rda_q != rdb_q) && rda_q[VERT_W] && rdb_q[VERT_W]) begin
						a_q <= rda_q[VERT_W-1:0];
						b_q <= rdb_q[VERT_W-1:0];
					end
					if (k_q == '0) begin
						state_q <= ST_Q_F;
					end else begin
						k_q     <= k_q - LVL_W'(1);
						state_q <= ST_Q_B;
					end
				end
				ST_Q_F: state_q <= ST_Q_FD;
				ST_Q_FD: begin
					if (rdb_q[VERT_W]) begin
						res_q  <= rdb_q[VERT_W-1:0];
						resv_q <= 1'b1;
					end
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (out_free) begin
						out_valid_q    <= 1'b1;
						ancestor_q     <= res_q;
						answer_valid_q <= resv_q;
						state_q        <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

@@ design/lca_chk.sv @@
// ----------------------------------------------------------------------------
// lca_chk
// Port-level checks of the LCA engine, bound to the top level.
// ----------------------------------------------------------------------------
module lca_chk (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 in_valid,
	input logic                 in_stall,
	input logic                 out_valid,
	input logic                 out_stall,
	input lca_pkg::vert_t       ancestor,
	input logic                 answer_valid
);
	import lca_pkg::*;

	// request in flight blocks the next one
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("request accepted while busy");

	// acknowledge without answer carries a zero vertex
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !answer_valid |-> ancestor == '0)
		else $error("acknowledge with nonzero ancestor");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("stalled result dropped");

	a_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(ancestor) && $stable(answer_valid))
		else $error("stalled result changed");

endmodule

bind lowest_common_ancestor_binary_lifting lca_chk u_lca_chk (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_valid),
	.in_stall     (in_stall),
	.out_valid    (out_valid),
	.out_stall    (out_stall),
	.ancestor     (ancestor),
	.answer_valid (answer_valid)
);

@@ verif/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the binary-lifting LCA engine: loads random trees
// under several vertex counts, builds the ancestor table and checks queries
// against an internal model of the table, with random idle and stall on both
// channels.
// ----------------------------------------------------------------------------
module testbench;
	import lca_pkg::*;

	localparam int WATCHDOG_LIMIT = 200000;

	typedef struct {
		vert_t anc;
		logic  av;
	} answer_t;

	typedef struct {
		logic [1:0] op;
		int         a;
		int         b;
		logic       hp;
		int         d;
		bit         typed;
		int         exp_anc;
		logic       exp_av;
	} row_t;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             in_valid = 1'b0;
	logic             in_stall;
	logic [1:0]       cmd = CMD_LOAD;
	vert_t            vertex_a = '0;
	vert_t            vertex_b = '0;
	logic             has_parent = 1'b0;
	vert_t            depth = '0;
	logic             out_valid;
	logic             out_stall = 1'b0;
	vert_t            ancestor;
	logic             answer_valid;
	logic             cfg_valid = 1'b0;
	logic             cfg_ready;
	logic [CNT_W-1:0] cfg_data = '0;

	lowest_common_ancestor_binary_lifting dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.cmd(cmd), .vertex_a(vertex_a), .vertex_b(vertex_b),
		.has_parent(has_parent), .depth(depth),
		.out_valid(out_valid), .out_stall(out_stall),
		.ancestor(ancestor), .answer_valid(answer_valid),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// model of the tables
	logic [ENT_W-1:0] lift_tab [MAX_VERTS][MAX_LEVELS];
	int               depth_mem [MAX_VERTS];
	int               vcount_reg = 1024;
	int               built_lv;
	answer_t          answers_q[$];
	int               errors = 0;
	bit               hold_req = 0;

	function automatic int active_n();
		int n;
		n = vcount_reg;
		if (n < 1) n = 1;
		if (n > MAX_VERTS) n = MAX_VERTS;
		return n;
	endfunction

	function automatic int levels_for(int n);
		int lv;
		int m;
		lv = 1;
		m = 1;
		while ((m << 1) < n) begin
			m = m << 1;
			lv++;
		end
		if (lv > MAX_LEVELS) lv = MAX_LEVELS;
		return lv;
	endfunction

	function automatic logic [ENT_W-1:0] ent(int v, int k);
		if (v >= MAX_VERTS || k >= MAX_LEVELS) return '0;
		return lift_tab[v][k];
	endfunction

	function automatic answer_t lca_apply(logic [1:0] op, int a, int b, logic hp, int d);
		answer_t r;
		int n, lv, da, db, t, diff;
		logic [ENT_W-1:0] p, ea, eb;
		r.anc = '0;
		r.av = 1'b0;
		if (op == CMD_LOAD) begin
			lift_tab[a][0] = hp ? {1'b1, vert_t'(b)} : '0;
			depth_mem[a] = d;
		end else if (op == CMD_BUILD) begin
			n = active_n();
			lv = levels_for(n);
			for (int k = 0; k + 1 < lv; k++)
				for (int v = 0; v < n; v++) begin
					p = lift_tab[v][k];
					lift_tab[v][k + 1] = p[VERT_W] ? ent(p[VERT_W-1:0], k) : '0;
				end
			built_lv = lv;
		end else if (op == CMD_QUERY) begin
			da = depth_mem[a];
			db = depth_mem[b];
			if (da < db) begin
				t = a; a = b; b = t;
				t = da; da = db; db = t;
			end
			diff = da - db;
			for (int k = built_lv - 1; k >= 0; k--)
				if ((diff >> k) & 1) begin
					ea = ent(a, k);
					if (!ea[VERT_W]) return r;
					a = ea[VERT_W-1:0];
				end
			if (a == b) begin
				r.anc = vert_t'(a);
				r.av = 1'b1;
				return r;
			end
			for (int k = built_lv - 1; k >= 0; k--) begin
				ea = ent(a, k);
				eb = ent(b, k);
				if (ea != eb && ea[VERT_W] && eb[VERT_W]) begin
					a = ea[VERT_W-1:0];
					b = eb[VERT_W-1:0];
				end
			end
			ea = ent(b, 0);
			if (ea[VERT_W]) begin
				r.anc = ea[VERT_W-1:0];
				r.av = 1'b1;
			end
		end
		return r;
	endfunction

	task automatic send(row_t rw);
		answer_t e;
		in_valid <= 1'b1;
		cmd <= rw.op;
		vertex_a <= vert_t'(rw.a);
		vertex_b <= vert_t'(rw.b);
		has_parent <= rw.hp;
		depth <= vert_t'(rw.d);
		do @(posedge clk); while (in_stall);
		e = lca_apply(rw.op, rw.a, rw.b, rw.hp, rw.d);
		if (rw.typed) begin
			e.anc = vert_t'(rw.exp_anc);
			e.av = rw.exp_av;
		end
		answers_q.push_back(e);
		if ($urandom_range(0, 2) != 0) begin
			int gap;
			gap = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic op_item(logic [1:0] op, int a, int b, logic hp, int d);
		row_t rw;
		rw = '{op, a, b, hp, d, 0, 0, 1'b0};
		send(rw);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (answers_q.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	task automatic write_count(int v);
		drain();
		cfg_valid <= 1'b1;
		cfg_data <= CNT_W'(v);
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		vcount_reg = v;
	endtask

	task automatic run_phase(int cnt, int nq, bit hold);
		int n, p, dd;
		int tdep [MAX_VERTS];
		write_count(cnt);
		n = active_n();
		for (int v = 0; v < n; v++) begin
			if (hold && v == n / 2) hold_req = 1;
			if (v == 0 || $urandom_range(0, 19) == 0) begin
				tdep[v] = 0;
				op_item(CMD_LOAD, v, $urandom_range(0, 1023), 1'b0, 0);
			end else begin
				p = ($urandom_range(0, 1) == 0) ? $urandom_range((v > 8) ? v - 8 : 0, v - 1)
					: $urandom_range(0, v - 1);
				if (tdep[p] >= 1023) begin
					tdep[v] = 0;
					op_item(CMD_LOAD, v, p, 1'b0, 0);
				end else begin
					tdep[v] = tdep[p] + 1;
					op_item(CMD_LOAD, v, p, 1'b1, tdep[v]);
				end
			end
		end
		op_item(CMD_BUILD, $urandom_range(0, 1023), $urandom_range(0, 1023), 1'b0, 0);
		for (int i = 0; i < nq; i++) begin
			dd = $urandom_range(0, 99);
			if (dd < 6)
				op_item(CMD_NOP, $urandom_range(0, 1023), $urandom_range(0, 1023),
					1'($urandom), $urandom_range(0, 1023));
			else if (dd < 14)
				op_item(CMD_LOAD, $urandom_range(0, n - 1), $urandom_range(0, n - 1),
					1'($urandom), $urandom_range(0, 1023));
			else if (dd < 17)
				op_item(CMD_BUILD, 0, 0, 1'b0, 0);
			else
				op_item(CMD_QUERY, $urandom_range(0, n - 1), $urandom_range(0, n - 1),
					1'($urandom), $urandom_range(0, 1023));
		end
	endtask

	row_t directed [] = '{
		'{CMD_LOAD, 0, 1023, 1'b0, 0, 1, 0, 1'b0},
		'{CMD_LOAD, 1, 0, 1'b1, 1, 1, 0, 1'b0},
		'{CMD_LOAD, 2, 0, 1'b1, 1, 0, 0, 1'b0},
		'{CMD_LOAD, 3, 1, 1'b1, 2, 0, 0, 1'b0},
		'{CMD_NOP, 1023, 1023, 1'b1, 1023, 1, 0, 1'b0},
		'{CMD_BUILD, 0, 0, 1'b0, 0, 1, 0, 1'b0},
		'{CMD_QUERY, 3, 2, 1'b0, 0, 1, 0, 1'b1},
		'{CMD_QUERY, 3, 3, 1'b0, 0, 1, 3, 1'b1},
		'{CMD_QUERY, 1, 3, 1'b0, 0, 1, 1, 1'b1},
		'{CMD_QUERY, 2, 1, 1'b1, 1023, 0, 0, 1'b0},
		'{CMD_LOAD, 2, 0, 1'b0, 0, 0, 0, 1'b0},
		'{CMD_QUERY, 3, 2, 1'b0, 0, 1, 0, 1'b0},
		'{CMD_LOAD, 3, 1, 1'b1, 1023, 0, 0, 1'b0},
		'{CMD_QUERY, 3, 0, 1'b0, 0, 1, 0, 1'b0},
		'{CMD_LOAD, 3, 1, 1'b1, 2, 0, 0, 1'b0},
		'{CMD_LOAD, 2, 0, 1'b1, 1, 0, 0, 1'b0},
		'{CMD_BUILD, 0, 0, 1'b0, 0, 0, 0, 1'b0},
		'{CMD_QUERY, 0, 0, 1'b0, 0, 1, 0, 1'b1},
		'{CMD_QUERY, 2, 3, 1'b0, 0, 0, 0, 1'b0}
	};

	initial begin
		int counts [] = '{0, 1, 2, 7, 16, 33, 100, 5, 64, 150};
		built_lv = levels_for(1024);
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		write_count(4);
		foreach (directed[i]) send(directed[i]);
		foreach (counts[i]) run_phase(counts[i], 30, counts[i] == 100);
		drain();
		repeat (50) @(posedge clk);
		if (errors == 0 && answers_q.size() == 0)
			$display("lowest_common_ancestor_binary_lifting: match");
		else
			$display("lowest_common_ancestor_binary_lifting: mismatch");
		$finish;
	end

	// result side: random stalls plus one long hold-off
	initial begin
		int left;
		int hold_left;
		left = 0;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (hold_req && hold_left == 0) begin
				hold_left = 400;
				hold_req = 0;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else if (left > 0) begin
				left--;
				out_stall <= 1'b1;
			end else if ($urandom_range(0, 3) == 0) begin
				left = ($urandom_range(0, 15) == 0) ? $urandom_range(10, 50)
					: $urandom_range(0, 2);
				out_stall <= 1'b1;
			end else
				out_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin
		answer_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (answers_q.size() == 0) begin
				$display("%0t: unexpected answer %0d/%0b", $time, ancestor, answer_valid);
				errors++;
			end else begin
				e = answers_q.pop_front();
				if (ancestor !== e.anc) begin
					$display("%0t: ancestor expected %0d actual %0d", $time, e.anc, ancestor);
					errors++;
				end
				if (answer_valid !== e.av) begin
					$display("%0t: answer_valid expected %0b actual %0b",
						$time, e.av, answer_valid);
					errors++;
				end
			end
		end
	end

	// watchdog on cycles without any request moving
	int quiet = 0;
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
			quiet <= 0;
		else if (quiet >= WATCHDOG_LIMIT) begin
			$display("lowest_common_ancestor_binary_lifting: mismatch");
			$finish;
		end else
			quiet <= quiet + 1;
	end

endmodule

@@ sim.f @@
design/lca_pkg.sv
design/lowest_common_ancestor_binary_lifting.sv
design/lca_chk.sv
verif/testbench.sv
